@@ src/sha_pkg.sv @@
// sha_pkg: shared types, round constants, initial hash values and state codes
// for the message hasher. No dependencies.
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;
  typedef logic [15:0][31:0] window_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_OUT
  } state_t;

  localparam int BlockWords = 16;
  localparam int Rounds = 64;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

@@ src/sha_if.sv @@
// sha_if: valid/ready channel interfaces for message bytes and digest words
// depends on nothing
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, byte_value, byte_present, end_of_message, input ready);
  modport sink (input valid, byte_value, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/sha_ram.sv @@
// sha_ram: generic single-write, single-read memory with registered read
// no dependencies
module sha_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/sha_round.sv @@
// sha_round: one compression round plus the message schedule word for it
// depends on sha_pkg
module sha_round (
  input  sha_pkg::hash_t   work,
  input  sha_pkg::window_t win,
  input  sha_pkg::word_t   block_word,
  input  logic             use_block,
  input  sha_pkg::word_t   k,
  output sha_pkg::word_t   w_t,
  output sha_pkg::hash_t   work_next
);
  import sha_pkg::*;

  function automatic word_t rotr(input word_t v, input int s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  word_t s0, s1, big0, big1, ch, maj, t1, t2;

  always_comb begin
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w_t = use_block ? block_word : (s1 + win[9] + s0 + win[0]);
    big1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    ch = (work[4] & work[5]) ^ (~work[4] & work[6]);
    t1 = work[7] + big1 + ch + k + w_t;
    big0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t2 = big0 + maj;
    work_next[7] = work[6];
    work_next[6] = work[5];
    work_next[5] = work[4];
    work_next[4] = work[3] + t1;
    work_next[3] = work[2];
    work_next[2] = work[1];
    work_next[1] = work[0];
    work_next[0] = t1 + t2;
  end
endmodule

@@ src/sha256_message_hasher.sv @@
// sha256_message_hasher: byte-stream SHA-256 with padding and digest output
// depends on sha_pkg, sha_if, sha_ram, sha_round
// Takes one message byte per transaction; the bytes are packed into words in a
// 16-word block memory. Each filled 64-byte block is then compressed by a memory
// read lead-in, 64 rounds of the single round unit and a fold into the hash. A
// closing transaction inserts 9 to 72 padding bytes at one per cycle, pausing for
// one or two block compressions, and returns the eight digest words, most
// significant first, one per output transaction. No new byte is taken meanwhile.
module sha256_message_hasher (
  input  logic             clk,
  input  logic             rst,
  sha_in_if.sink           msg,
  sha_out_if.source        dig
);
  import sha_pkg::*;

  state_t     state, state_next;
  logic [5:0] fill;
  logic [31:0] acc;
  logic [63:0] msg_bits;
  logic       pad_active, pad_first, len_phase, pad_done;
  logic [2:0] len_idx, idx;
  logic [5:0] rcnt;
  hash_t      chain, work, work_next;
  window_t    win;
  word_t      w_t, rdata;
  logic       put_en, len_put, full, accept;
  logic [7:0] put_val;
  logic [2:0] lsel;
  logic [3:0] raddr;

  assign accept = msg.valid && msg.ready;

  always_comb begin
    put_en = 1'b0;
    put_val = '0;
    len_put = 1'b0;
    lsel = 3'(3'd7 - len_idx);
    case (state)
      S_IDLE: begin
        if (accept && msg.byte_present) begin
          put_en = 1'b1;
          put_val = msg.byte_value;
        end
      end
      S_PAD: begin
        put_en = 1'b1;
        if (pad_first) begin
          put_val = PadByte;
        end else if (len_phase || fill == LenStart) begin
          len_put = 1'b1;
          put_val = msg_bits[{lsel, 3'b000} +: 8];
        end
      end
      default: ;
    endcase
    full = put_en && (fill == 6'd63);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (full) state_next = S_LOAD;
          else if (msg.end_of_message) state_next = S_PAD;
        end
      end
      S_LOAD: state_next = S_ROUND;
      S_ROUND: if (rcnt == 6'(Rounds - 1)) state_next = S_FOLD;
      S_FOLD: begin
        if (!pad_active) state_next = S_IDLE;
        else if (pad_done) state_next = S_OUT;
        else state_next = S_PAD;
      end
      S_PAD: if (full) state_next = S_LOAD;
      S_OUT: if (dig.ready && idx == 3'd7) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    msg.ready = (state == S_IDLE);
    dig.valid = (state == S_OUT);
    dig.digest_word = chain[idx];
    dig.word_index = idx;
    dig.last_word = (idx == 3'd7);
    raddr = (state == S_ROUND) ? 4'(rcnt[3:0] + 4'd1) : 4'd0;
  end

  sha_ram #(.Width(32), .Depth(BlockWords)) u_block (
    .clk   (clk),
    .we    (put_en && fill[1:0] == 2'd3),
    .waddr (fill[5:2]),
    .wdata ({acc[23:0], put_val}),
    .raddr (raddr),
    .rdata (rdata)
  );

  sha_round u_round (
    .work       (work),
    .win        (win),
    .block_word (rdata),
    .use_block  (rcnt < 6'd16),
    .k          (RoundK[rcnt]),
    .w_t        (w_t),
    .work_next  (work_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      msg_bits <= '0;
      pad_active <= 1'b0;
      pad_first <= 1'b0;
      len_phase <= 1'b0;
      pad_done <= 1'b0;
      len_idx <= '0;
      idx <= '0;
      rcnt <= '0;
      chain <= InitHash;
    end else begin
      state <= state_next;
      if (put_en) begin
        acc <= {acc[23:0], put_val};
        fill <= 6'(fill + 6'd1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (msg.byte_present) msg_bits <= 64'(msg_bits + 64'd8);
            if (msg.end_of_message) begin
              pad_active <= 1'b1;
              pad_first <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          work <= chain;
          rcnt <= '0;
        end
        S_ROUND: begin
          work <= work_next;
          win <= {w_t, win[15:1]};
          rcnt <= 6'(rcnt + 6'd1);
        end
        S_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
        end
        S_PAD: begin
          pad_first <= 1'b0;
          if (len_put) begin
            len_phase <= 1'b1;
            len_idx <= 3'(len_idx + 3'd1);
            if (len_idx == 3'd7) pad_done <= 1'b1;
          end
        end
        S_OUT: begin
          if (dig.ready) begin
            idx <= 3'(idx + 3'd1);
            if (idx == 3'd7) begin
              chain <= InitHash;
              msg_bits <= '0;
              pad_active <= 1'b0;
              len_phase <= 1'b0;
              pad_done <= 1'b0;
              len_idx <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

@@ src/sha_checker.sv @@
// sha_checker: port-level checks on the message hasher, bound to the top level
// depends on sha256_message_hasher ports
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed while stalled");

  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && word_index == 3'($past(word_index) + 3'd1))
    else $error("digest words out of order");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_word == (word_index == 3'd7))
    else $error("last flag mismatch");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while digest pending");
endmodule

bind sha256_message_hasher sha_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (msg.ready),
  .out_valid   (dig.valid),
  .out_ready   (dig.ready),
  .digest_word (dig.digest_word),
  .word_index  (dig.word_index),
  .last_word   (dig.last_word)
);
